### hw/rtl/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// shared types, codes and defaults for the keyed record table
// ----------------------------------------------------------------------------
package krt_pkg;

	localparam int TABLE_ENTRIES_DEF = 128;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2,
		OP_UPDATE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2,
		ST_MISS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_SHIFT  = 2'd2,
		CMD_UPDATE = 2'd3
	} cmd_kind_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_state_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] key;
		logic [63:0]        name_tag;
		logic [63:0]        category_tag;
		logic [31:0]        price_cents;
		logic signed [31:0] amount;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [63:0]        found_name;
		logic [63:0]        found_category;
		logic [31:0]        found_price;
		logic signed [31:0] found_amount;
		logic [7:0]         entry_count;
	} rsp_t;

	// one stored record
	typedef struct packed {
		logic [31:0] key;
		logic [63:0] name_tag;
		logic [63:0] category_tag;
		logic [31:0] price_cents;
		logic [31:0] amount;
	} rec_t;

	// command broadcast to every cell
	typedef struct packed {
		cmd_kind_t kind;
		rec_t      rec;
	} cell_cmd_t;

endpackage

### hw/rtl/krt_stream_if.sv
// ----------------------------------------------------------------------------
// krt_stream_if
// valid/ready channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
interface krt_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/krt_cell.sv
// ----------------------------------------------------------------------------
// krt_cell
// one table slot: holds a record, compares its key, takes its neighbor's
// record on a remove
// ----------------------------------------------------------------------------
module krt_cell #(
	parameter int TABLE_ENTRIES = krt_pkg::TABLE_ENTRIES_DEF,
	parameter int CELL_IDX      = 0,
	localparam int IDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int CNT_W        = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmp_en,
	input  logic [31:0]         cmp_key,
	input  logic [CNT_W-1:0]    count,
	input  logic [IDX_W-1:0]    hit_idx,
	input  krt_pkg::cell_cmd_t  cmd,
	input  krt_pkg::rec_t       next_rec,
	output krt_pkg::rec_t       rec,
	output logic                match,
	output krt_pkg::rec_t       found_rec
);

	localparam logic [CNT_W-1:0] POS_CNT = CNT_W'(CELL_IDX);
	localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(CELL_IDX);

	krt_pkg::rec_t rec_q;
	krt_pkg::rec_t rec_d;
	logic          match_q;

	always_comb begin
		rec_d = rec_q;
		unique case (cmd.kind)
			krt_pkg::CMD_NONE: begin
			end
			krt_pkg::CMD_APPEND: begin
				if (POS_CNT == count) begin
					rec_d = cmd.rec;
				end
			end
			krt_pkg::CMD_SHIFT: begin
				// every slot at or above the hole takes the one above it
				if (POS_IDX >= hit_idx) begin
					rec_d = next_rec;
				end
			end
			krt_pkg::CMD_UPDATE: begin
				if (POS_IDX == hit_idx) begin
					rec_d     = cmd.rec;
					rec_d.key = rec_q.key;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rec_q <= rec_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (cmp_en) begin
			match_q <= (POS_CNT < count) && (rec_q.key == cmp_key);
		end
	end

	assign rec       = rec_q;
	assign match     = match_q;
	assign found_rec = match_q ? rec_q : '0;

endmodule

### hw/rtl/keyed_record_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// keyed record table built as a row of slot cells kept in insertion order
// ----------------------------------------------------------------------------
//  channel  dir  payload  transfer when
//  req      in   req_t    req.valid && req.ready
//  rsp      out  rsp_t    rsp.valid && rsp.ready
//
//  each operation: the accept edge loads the key compare in all cells at
//  once, and the execute step then applies the append, shift or update and
//  loads the result register. req.ready is high only in the idle state.
//  a waiting result holds the execute step until the slot frees up.
//  reset empties the table at once; stored records need no clearing.
module keyed_record_table_unit #(
	parameter int TABLE_ENTRIES = krt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	krt_stream_if.sink   req,
	krt_stream_if.source rsp
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

	krt_pkg::fsm_state_t state_q, state_d;
	krt_pkg::req_t       req_q;
	logic [CNT_W-1:0]    count_q, count_d;
	logic                out_valid_q;
	krt_pkg::rsp_t       out_data_q;

	logic                req_fire;
	logic                exe_fire;
	logic                in_rdy;

	krt_pkg::rec_t       cell_rec   [TABLE_ENTRIES];
	krt_pkg::rec_t       found_part [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] match_vec;

	logic [IDX_W-1:0]    hit_idx;
	logic                hit;
	logic                full;
	krt_pkg::rec_t       found_rec;
	krt_pkg::cell_cmd_t  cmd;
	krt_pkg::cmd_kind_t  kind;
	krt_pkg::status_t    status;
	krt_pkg::rec_t       rsp_rec;
	logic [CNT_W+7:0]    count_ext;

	// ---------------- control
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			krt_pkg::FSM_IDLE: if (req.valid) state_d = krt_pkg::FSM_EXEC;
			krt_pkg::FSM_EXEC: if (!out_valid_q || rsp.ready) state_d = krt_pkg::FSM_IDLE;
			default:           state_d = krt_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		in_rdy   = 1'b0;
		exe_fire = 1'b0;
		unique case (state_q)
			krt_pkg::FSM_IDLE: in_rdy   = 1'b1;
			krt_pkg::FSM_EXEC: exe_fire = !out_valid_q || rsp.ready;
			default: begin
			end
		endcase
	end

	assign req.ready = in_rdy;
	assign req_fire  = req.valid && in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krt_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req.data;
		end
	end

	// ---------------- match reduction (keys are unique, so at most one hit)
	always_comb begin
		hit_idx   = '0;
		found_rec = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (match_vec[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
			found_rec = found_rec | found_part[i];
		end
	end

	assign hit  = |match_vec;
	assign full = (count_q == FULL_CNT);

	always_comb begin
		status  = krt_pkg::ST_DONE;
		kind    = krt_pkg::CMD_NONE;
		count_d = count_q;
		rsp_rec = '0;
		unique case (req_q.op)
			krt_pkg::OP_ADD: begin
				if (hit) begin
					status = krt_pkg::ST_DUP;
				end else if (full) begin
					status = krt_pkg::ST_FULL;
				end else begin
					kind    = krt_pkg::CMD_APPEND;
					count_d = count_q + CNT_W'(1);
				end
			end
			krt_pkg::OP_REMOVE: begin
				if (!hit) begin
					status = krt_pkg::ST_MISS;
				end else begin
					kind    = krt_pkg::CMD_SHIFT;
					count_d = count_q - CNT_W'(1);
				end
			end
			krt_pkg::OP_FIND: begin
				if (!hit) begin
					status = krt_pkg::ST_MISS;
				end else begin
					rsp_rec = found_rec;
				end
			end
			krt_pkg::OP_UPDATE: begin
				if (!hit) begin
					status = krt_pkg::ST_MISS;
				end else begin
					kind = krt_pkg::CMD_UPDATE;
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd.kind             = exe_fire ? kind : krt_pkg::CMD_NONE;
	assign cmd.rec.key          = req_q.key;
	assign cmd.rec.name_tag     = req_q.name_tag;
	assign cmd.rec.category_tag = req_q.category_tag;
	assign cmd.rec.price_cents  = req_q.price_cents;
	assign cmd.rec.amount       = req_q.amount;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exe_fire) begin
			count_q <= count_d;
		end
	end

	// ---------------- cell row
	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		krt_pkg::rec_t nbr;
		if (g < TABLE_ENTRIES - 1) begin : g_mid
			assign nbr = cell_rec[g+1];
		end else begin : g_last
			assign nbr = cell_rec[g];
		end

		krt_cell #(
			.TABLE_ENTRIES (TABLE_ENTRIES),
			.CELL_IDX      (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmp_en    (req_fire),
			.cmp_key   (req.data.key),
			.count     (count_q),
			.hit_idx   (hit_idx),
			.cmd       (cmd),
			.next_rec  (nbr),
			.rec       (cell_rec[g]),
			.match     (match_vec[g]),
			.found_rec (found_part[g])
		);
	end

	// ---------------- result register
	assign count_ext = {8'd0, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exe_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exe_fire) begin
			out_data_q.status         <= status;
			out_data_q.found_name     <= rsp_rec.name_tag;
			out_data_q.found_category <= rsp_rec.category_tag;
			out_data_q.found_price    <= rsp_rec.price_cents;
			out_data_q.found_amount   <= rsp_rec.amount;
			out_data_q.entry_count    <= count_ext[7:0];
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

`ifndef SYNTHESIS
	// stored keys stay unique
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == krt_pkg::FSM_EXEC |-> $onehot0(match_vec))
		else $error("more than one cell matched the key");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("record count above table size");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == krt_pkg::FSM_IDLE |=> $stable(count_q))
		else $error("record count moved outside execute step");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == krt_pkg::FSM_EXEC))
		else $error("result appeared without an execute step");
`endif

endmodule
